>>> rtl/tppg_pkg.sv
// Shared constants, types and codes of the test pattern pixel generator.
`default_nettype none

package tppg_pkg;

  // Frame geometry; the ring centre sits at the middle of the frame.
  localparam int FRAME_WIDTH  = 1024;
  localparam int FRAME_HEIGHT = 768;

  localparam int COORD_W    = 10;
  localparam int LEVEL_W    = 8;
  localparam int SIZE_W     = 10;
  localparam int MODE_W     = 2;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 10;

  localparam int CENTER_X  = FRAME_WIDTH / 2;
  localparam int CENTER_Y  = FRAME_HEIGHT / 2;
  localparam int COORD_MAX = (1 << COORD_W) - 1;

  // Largest distance from the centre along one axis.
  localparam int CENTER_MAX = (CENTER_X > CENTER_Y) ? CENTER_X : CENTER_Y;
  localparam int OFF_MAX    = (CENTER_MAX > COORD_MAX) ? CENTER_MAX : COORD_MAX;
  localparam int OFF_W      = $clog2(OFF_MAX + 1);

  // Squared radius, square root rounds and root width.
  localparam int SQ_W        = 2 * OFF_W + 1;
  localparam int ROOT_ROUNDS = (SQ_W + 1) / 2;
  localparam int ROOT_W      = ROOT_ROUNDS;
  localparam int ROOT_ACC_W  = SQ_W + 1;

  // Dividend width shared by the coordinate and radius lanes of the divider.
  localparam int DIV_W     = (ROOT_W > COORD_W) ? ROOT_W : COORD_W;
  localparam int DIV_LANES = 3;
  localparam int LANE_X    = 0;
  localparam int LANE_Y    = 1;
  localparam int LANE_R    = 2;

  localparam logic [LEVEL_W-1:0] LEVEL_HIGH = 8'd230;
  localparam logic [LEVEL_W-1:0] LEVEL_LOW  = 8'd25;

  typedef enum logic [MODE_W-1:0] {
    MODE_BLANK   = 2'd0,
    MODE_CHECKER = 2'd1,
    MODE_RINGS   = 2'd2
  } mode_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_MODE  = 2'd0,
    REG_BLANK = 2'd1,
    REG_CELL  = 2'd2,
    REG_RING  = 2'd3
  } cfg_reg_t;

  localparam mode_t               MODE_RESET  = MODE_BLANK;
  localparam logic [LEVEL_W-1:0]  BLANK_RESET = 8'd25;
  localparam logic [SIZE_W-1:0]   CELL_RESET  = 10'd32;
  localparam logic [SIZE_W-1:0]   RING_RESET  = 10'd32;

  // A pixel coordinate travelling down the pipeline with its valid bit.
  typedef struct packed {
    logic               valid;
    logic [COORD_W-1:0] x;
    logic [COORD_W-1:0] y;
  } pix_t;

  typedef logic [DIV_LANES-1:0][DIV_W-1:0]  div_num_t;
  typedef logic [DIV_LANES-1:0][SIZE_W-1:0] div_den_t;

endpackage

`default_nettype wire

>>> rtl/tppg_front.sv
// Front end: axis offsets from the frame centre, their squares and the squared radius.
`default_nettype none

module tppg_front (
  input  wire logic                    clk,
  input  wire logic                    rst_n,
  input  wire logic                    en,
  input  wire tppg_pkg::pix_t          in_pix,
  output tppg_pkg::pix_t               out_pix,
  output logic [tppg_pkg::SQ_W-1:0]    out_sq
);
  import tppg_pkg::*;

  localparam logic [OFF_W-1:0] CX = OFF_W'(CENTER_X);
  localparam logic [OFF_W-1:0] CY = OFF_W'(CENTER_Y);

  logic [OFF_W-1:0]   x_ext;
  logic [OFF_W-1:0]   y_ext;
  logic [OFF_W-1:0]   dx_nxt;
  logic [OFF_W-1:0]   dy_nxt;
  logic [OFF_W-1:0]   dx_r;
  logic [OFF_W-1:0]   dy_r;
  logic [2*OFF_W-1:0] dx2_r;
  logic [2*OFF_W-1:0] dy2_r;
  logic [SQ_W-1:0]    sq_r;
  pix_t               pix_a_r;
  pix_t               pix_b_r;
  pix_t               pix_c_r;

  always_comb begin
    x_ext  = OFF_W'(in_pix.x);
    y_ext  = OFF_W'(in_pix.y);
    dx_nxt = (x_ext >= CX) ? (x_ext - CX) : (CX - x_ext);
    dy_nxt = (y_ext >= CY) ? (y_ext - CY) : (CY - y_ext);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pix_a_r.valid <= 1'b0;
      pix_b_r.valid <= 1'b0;
      pix_c_r.valid <= 1'b0;
    end else if (en) begin
      pix_a_r <= in_pix;
      pix_b_r <= pix_a_r;
      pix_c_r <= pix_b_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dx_r  <= dx_nxt;
      dy_r  <= dy_nxt;
      dx2_r <= dx_r * dx_r;
      dy2_r <= dy_r * dy_r;
      sq_r  <= SQ_W'(dx2_r) + SQ_W'(dy2_r);
    end
  end

  assign out_pix = pix_c_r;
  assign out_sq  = sq_r;

endmodule

`default_nettype wire

>>> rtl/tppg_isqrt.sv
// Pipelined bit-by-bit integer square root, one round per register stage.
`default_nettype none

module tppg_isqrt (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic                      en,
  input  wire tppg_pkg::pix_t            in_pix,
  input  wire logic [tppg_pkg::SQ_W-1:0] in_sq,
  output tppg_pkg::pix_t                 out_pix,
  output logic [tppg_pkg::ROOT_W-1:0]    out_root,
  output logic [tppg_pkg::SQ_W-1:0]      out_rem
);
  import tppg_pkg::*;

  logic [SQ_W-1:0]       v_r   [ROOT_ROUNDS];
  logic [ROOT_ACC_W-1:0] acc_r [ROOT_ROUNDS];
  pix_t                  pix_r [ROOT_ROUNDS];

  for (genvar k = 0; k < ROOT_ROUNDS; k++) begin : g_round
    localparam int SHIFT = 2 * (ROOT_ROUNDS - 1 - k);
    localparam logic [ROOT_ACC_W-1:0] BIT = {{(ROOT_ACC_W-1){1'b0}}, 1'b1} << SHIFT;

    logic [SQ_W-1:0]       v_in;
    logic [ROOT_ACC_W-1:0] acc_in;
    pix_t                  pix_in;
    logic [ROOT_ACC_W:0]   trial;
    logic                  take;
    logic [SQ_W-1:0]       v_nxt;
    logic [ROOT_ACC_W-1:0] acc_nxt;

    if (k == 0) begin : g_first
      assign v_in   = in_sq;
      assign acc_in = '0;
      assign pix_in = in_pix;
    end else begin : g_next
      assign v_in   = v_r[k-1];
      assign acc_in = acc_r[k-1];
      assign pix_in = pix_r[k-1];
    end

    always_comb begin
      trial   = {1'b0, acc_in} + {1'b0, BIT};
      take    = ((ROOT_ACC_W+1)'(v_in) >= trial);
      v_nxt   = take ? (v_in - trial[SQ_W-1:0]) : v_in;
      acc_nxt = take ? ((acc_in >> 1) + BIT) : (acc_in >> 1);
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        pix_r[k].valid <= 1'b0;
      end else if (en) begin
        pix_r[k] <= pix_in;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        v_r[k]   <= v_nxt;
        acc_r[k] <= acc_nxt;
      end
    end
  end

  assign out_pix  = pix_r[ROOT_ROUNDS-1];
  assign out_root = acc_r[ROOT_ROUNDS-1][ROOT_W-1:0];
  assign out_rem  = v_r[ROOT_ROUNDS-1];

endmodule

`default_nettype wire

>>> rtl/tppg_div_pipe.sv
// Pipelined restoring divider over three lanes; it yields the parity of each quotient.
`default_nettype none

module tppg_div_pipe (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic                      en,
  input  wire logic                      in_valid,
  input  wire tppg_pkg::div_num_t        in_num,
  input  wire tppg_pkg::div_den_t        in_den,
  output logic                           out_valid,
  output logic [tppg_pkg::DIV_LANES-1:0] out_odd
);
  import tppg_pkg::*;

  logic                   valid_r [DIV_W];
  div_num_t               num_r   [DIV_W];
  div_den_t               rem_r   [DIV_W];
  logic [DIV_LANES-1:0]   q_r     [DIV_W];

  // Stage k brings down one dividend bit per lane, most significant first.
  for (genvar k = 0; k < DIV_W; k++) begin : g_step
    logic                 valid_in;
    div_num_t             num_in;
    div_den_t             rem_in;
    div_num_t             num_nxt;
    div_den_t             rem_nxt;
    logic [DIV_LANES-1:0] q_nxt;
    logic [SIZE_W:0]      part;

    if (k == 0) begin : g_first
      assign valid_in = in_valid;
      assign num_in   = in_num;
      assign rem_in   = '0;
    end else begin : g_next
      assign valid_in = valid_r[k-1];
      assign num_in   = num_r[k-1];
      assign rem_in   = rem_r[k-1];
    end

    always_comb begin
      part = '0;
      for (int j = 0; j < DIV_LANES; j++) begin
        part       = {rem_in[j], num_in[j][DIV_W-1]};
        num_nxt[j] = num_in[j] << 1;
        if (part >= {1'b0, in_den[j]}) begin
          q_nxt[j]   = 1'b1;
          rem_nxt[j] = SIZE_W'(part - {1'b0, in_den[j]});
        end else begin
          q_nxt[j]   = 1'b0;
          rem_nxt[j] = part[SIZE_W-1:0];
        end
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        valid_r[k] <= 1'b0;
      end else if (en) begin
        valid_r[k] <= valid_in;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        num_r[k] <= num_nxt;
        rem_r[k] <= rem_nxt;
        q_r[k]   <= q_nxt;
      end
    end
  end

  assign out_valid = valid_r[DIV_W-1];
  assign out_odd   = q_r[DIV_W-1];

endmodule

`default_nettype wire

>>> rtl/test_pattern_pixel_generator_top.sv
// Top level of the test pattern pixel generator: config registers, pipeline and output word.
//
// Usage: each input word carries one pixel coordinate (in_pixel_x, in_pixel_y); each
// output word carries its gray level in out_pixel_level, one output word per input word.
// Both channels use valid/stall; a word moves at a clock edge with valid high and stall low.
// The pattern is chosen by the config registers (mode, blank level, cell size, ring width),
// written through cfg_valid/cfg_index/cfg_data. cfg_ready is always high; write only while
// the pipeline is empty.
// Throughput is one pixel per clock while no output word is held. From the accepting edge
// to out_valid a word passes an input register, three front stages (offsets, squares, sum),
// one stage per square root round and one stage per quotient bit of the divider, then the
// output register.
// The whole pipeline advances together. While an output word waits with out_stall high,
// in_stall is high and every stage holds; no word is lost or repeated.
// A synchronous reset (rst_n low) empties the pipeline and loads the register defaults:
// blank mode, blank level 25, cell size 32, ring width 32.
`default_nettype none

module test_pattern_pixel_generator_top (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            in_valid,
  output logic                                 in_stall,
  input  wire logic [tppg_pkg::COORD_W-1:0]    in_pixel_x,
  input  wire logic [tppg_pkg::COORD_W-1:0]    in_pixel_y,
  output logic                                 out_valid,
  input  wire logic                            out_stall,
  output logic [tppg_pkg::LEVEL_W-1:0]         out_pixel_level,
  input  wire logic                            cfg_valid,
  output logic                                 cfg_ready,
  input  wire logic [tppg_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [tppg_pkg::CFG_DATA_W-1:0] cfg_data
);
  import tppg_pkg::*;

  mode_t               mode_r;
  logic [LEVEL_W-1:0]  blank_r;
  logic [SIZE_W-1:0]   cell_r;
  logic [SIZE_W-1:0]   ring_r;
  logic [SIZE_W-1:0]   cell_eff;
  logic [SIZE_W-1:0]   ring_eff;

  logic                en;
  pix_t                pix_in_nxt;
  pix_t                pix_in_r;
  pix_t                front_pix;
  logic [SQ_W-1:0]     front_sq;
  pix_t                root_pix;
  logic [ROOT_W-1:0]   root;
  logic [SQ_W-1:0]     root_rem;
  div_num_t            div_num;
  div_den_t            div_den;
  logic                div_valid;
  logic [DIV_LANES-1:0] div_odd;

  logic                out_valid_r;
  logic [LEVEL_W-1:0]  level_nxt;
  logic [LEVEL_W-1:0]  level_r;

  // Configuration registers.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r  <= MODE_RESET;
      blank_r <= BLANK_RESET;
      cell_r  <= CELL_RESET;
      ring_r  <= RING_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_reg_t'(cfg_index))
        REG_MODE:  mode_r  <= mode_t'(cfg_data[MODE_W-1:0]);
        REG_BLANK: blank_r <= cfg_data[LEVEL_W-1:0];
        REG_CELL:  cell_r  <= cfg_data[SIZE_W-1:0];
        REG_RING:  ring_r  <= cfg_data[SIZE_W-1:0];
        default:   ;
      endcase
    end
  end

  // A zero size is treated as one.
  assign cell_eff = (cell_r == '0) ? SIZE_W'(1) : cell_r;
  assign ring_eff = (ring_r == '0) ? SIZE_W'(1) : ring_r;

  // The pipeline moves unless the output word is held.
  assign en       = !out_valid_r || !out_stall;
  assign in_stall = !en;

  always_comb begin
    pix_in_nxt.valid = in_valid;
    pix_in_nxt.x     = in_pixel_x;
    pix_in_nxt.y     = in_pixel_y;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pix_in_r.valid <= 1'b0;
    end else if (en) begin
      pix_in_r <= pix_in_nxt;
    end
  end

  tppg_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .en      (en),
    .in_pix  (pix_in_r),
    .out_pix (front_pix),
    .out_sq  (front_sq)
  );

  tppg_isqrt u_isqrt (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .in_pix   (front_pix),
    .in_sq    (front_sq),
    .out_pix  (root_pix),
    .out_root (root),
    .out_rem  (root_rem)
  );

  always_comb begin
    div_num[LANE_X] = DIV_W'(root_pix.x);
    div_num[LANE_Y] = DIV_W'(root_pix.y);
    div_num[LANE_R] = DIV_W'(root);
    div_den[LANE_X] = cell_eff;
    div_den[LANE_Y] = cell_eff;
    div_den[LANE_R] = ring_eff;
  end

  tppg_div_pipe u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (root_pix.valid),
    .in_num    (div_num),
    .in_den    (div_den),
    .out_valid (div_valid),
    .out_odd   (div_odd)
  );

  // The sum of the two quotients is odd exactly when their parities differ.
  always_comb begin
    case (mode_r)
      MODE_CHECKER: level_nxt = (div_odd[LANE_X] ^ div_odd[LANE_Y]) ? LEVEL_HIGH : LEVEL_LOW;
      MODE_RINGS:   level_nxt = div_odd[LANE_R] ? LEVEL_HIGH : LEVEL_LOW;
      default:      level_nxt = blank_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= div_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      level_r <= level_nxt;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_pixel_level = level_r;

  // The square root remainder never exceeds twice the root.
  a_root_rem : assert property (@(posedge clk) disable iff (!rst_n)
    root_pix.valid |-> (root_rem <= SQ_W'({root, 1'b0})))
    else $error("square root remainder out of range");

  // Pattern modes only ever give one of the two fixed levels.
  a_pattern_level : assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (mode_r == MODE_CHECKER || mode_r == MODE_RINGS)) |->
      (out_pixel_level == LEVEL_HIGH || out_pixel_level == LEVEL_LOW))
    else $error("pattern level is neither high nor low");

  // A held output word freezes the pipeline, so the input must stall too.
  a_hold_input : assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |-> in_stall)
    else $error("input accepted while output word is held");

endmodule

`default_nettype wire

>>> dv/tb.sv
// Self-checking testbench for the test pattern pixel generator.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import tppg_pkg::*;

  typedef struct {
    logic [COORD_W-1:0] x;
    logic [COORD_W-1:0] y;
    logic [LEVEL_W-1:0] level;
  } pixel_word_t;

  logic                  clk;
  logic                  rst_n;
  logic                  in_valid;
  logic                  in_stall;
  logic [COORD_W-1:0]    in_pixel_x;
  logic [COORD_W-1:0]    in_pixel_y;
  logic                  out_valid;
  logic                  out_stall;
  logic [LEVEL_W-1:0]    out_pixel_level;
  logic                  cfg_valid;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  // Copy of the pattern registers as the block should hold them.
  logic [MODE_W-1:0]  mode_q;
  logic [LEVEL_W-1:0] blank_q;
  logic [SIZE_W-1:0]  cell_q;
  logic [SIZE_W-1:0]  ring_q;

  pixel_word_t expected_levels[$];
  int          mismatches;
  int          pixels_sent;
  bit          gaps_on;

  test_pattern_pixel_generator_top i_dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_pixel_x      (in_pixel_x),
    .in_pixel_y      (in_pixel_y),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_pixel_level (out_pixel_level),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #1ms;
    $display("[FAIL] regression broken");
    $finish;
  end

  // Bit-serial integer square root, two bits of the radicand per round.
  function automatic logic [31:0] square_root(logic [31:0] radicand);
    logic [31:0] root;
    logic [31:0] probe;
    root  = '0;
    probe = 32'd1 << 30;
    for (int round = 0; round < 16; round++) begin
      if (radicand >= root + probe) begin
        radicand = radicand - (root + probe);
        root     = (root >> 1) + probe;
      end else begin
        root = root >> 1;
      end
      probe = probe >> 2;
    end
    return root;
  endfunction

  function automatic logic [LEVEL_W-1:0] expected_level(logic [COORD_W-1:0] x,
                                                         logic [COORD_W-1:0] y);
    logic [31:0] divisor;
    logic [31:0] dx;
    logic [31:0] dy;
    logic [31:0] band;
    case (mode_q)
      MODE_CHECKER: begin
        divisor = (cell_q == 0) ? 32'd1 : 32'(cell_q);
        band    = 32'(x) / divisor + 32'(y) / divisor;
      end
      MODE_RINGS: begin
        divisor = (ring_q == 0) ? 32'd1 : 32'(ring_q);
        dx      = (32'(x) >= CENTER_X) ? 32'(x) - CENTER_X : CENTER_X - 32'(x);
        dy      = (32'(y) >= CENTER_Y) ? 32'(y) - CENTER_Y : CENTER_Y - 32'(y);
        band    = square_root(dx * dx + dy * dy) / divisor;
      end
      default: return blank_q;
    endcase
    return band[0] ? LEVEL_HIGH : LEVEL_LOW;
  endfunction

  // Leaves in_valid high after the handshake so that a following word can go back to back.
  task automatic send_pixel(input logic [COORD_W-1:0] x, input logic [COORD_W-1:0] y);
    int          gap;
    pixel_word_t word;
    gap = gaps_on ? $urandom_range(0, 6) : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid   <= 1'b1;
    in_pixel_x <= x;
    in_pixel_y <= y;
    do @(posedge clk); while (in_stall);
    word.x     = x;
    word.y     = y;
    word.level = expected_level(x, y);
    expected_levels.push_back(word);
    pixels_sent++;
  endtask

  // Registers change only with the pipeline empty; every word yields a result,
  // so an empty expectation queue means nothing is in flight.
  task automatic write_reg(input cfg_reg_t which, input logic [CFG_DATA_W-1:0] data);
    in_valid <= 1'b0;
    while (expected_levels.size() != 0) @(posedge clk);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= which;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    case (which)
      REG_MODE:  mode_q  = data[MODE_W-1:0];
      REG_BLANK: blank_q = data[LEVEL_W-1:0];
      REG_CELL:  cell_q  = data[SIZE_W-1:0];
      REG_RING:  ring_q  = data[SIZE_W-1:0];
      default: ;
    endcase
  endtask

  function automatic logic [SIZE_W-1:0] draw_size();
    int pick;
    pick = $urandom_range(0, 9);
    case (pick)
      0: return '0;
      1: return 10'd1;
      2: return 10'd1023;
      3, 4: return SIZE_W'($urandom_range(1, 1023));
      default: return SIZE_W'($urandom_range(1, 64));
    endcase
  endfunction

  // While gaps are on, the result side may raise out_stall ahead of every word.
  initial begin
    int hold;
    out_stall <= 1'b0;
    @(posedge clk);
    forever begin
      hold = gaps_on ? $urandom_range(0, 6) : 0;
      repeat (hold) begin
        out_stall <= 1'b1;
        @(posedge clk);
      end
      out_stall <= 1'b0;
      do @(posedge clk); while (!out_valid);
    end
  end

  always @(posedge clk) begin : check_result
    pixel_word_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (expected_levels.size() == 0) begin
        mismatches++;
        $display("%0t: unexpected word: expected none, actual level %0d",
                 $time, out_pixel_level);
      end else begin
        want = expected_levels.pop_front();
        if (out_pixel_level !== want.level) begin
          mismatches++;
          if (mismatches <= 200)
            $display("%0t: level of pixel (%0d,%0d): expected %0d, actual %0d",
                     $time, want.x, want.y, want.level, out_pixel_level);
        end
      end
    end
  end

  // Reset values: blank mode at 25 first, then the other modes on the reset sizes.
  task automatic test_reset_defaults();
    send_pixel(10'd0, 10'd0);
    send_pixel(10'd1023, 10'd1023);
    write_reg(REG_MODE, CFG_DATA_W'(MODE_CHECKER));
    send_pixel(10'd31, 10'd32);
    send_pixel(10'd64, 10'd100);
    write_reg(REG_MODE, CFG_DATA_W'(MODE_RINGS));
    send_pixel(10'd512, 10'd384);
    send_pixel(10'd560, 10'd384);
  endtask

  task automatic test_blank_levels();
    write_reg(REG_MODE, CFG_DATA_W'(MODE_BLANK));
    write_reg(REG_BLANK, 10'd0);
    send_pixel(10'd700, 10'd200);
    write_reg(REG_BLANK, 10'd255);
    send_pixel(10'd5, 10'd767);
    // The unused mode code falls back to the blank level; upper data bits are dropped.
    write_reg(REG_MODE, {8'hA5, 2'd3});
    write_reg(REG_BLANK, {2'b11, 8'd77});
    send_pixel(10'd300, 10'd300);
  endtask

  task automatic test_checker_cells();
    write_reg(REG_MODE, CFG_DATA_W'(MODE_CHECKER));
    write_reg(REG_CELL, 10'd1);
    send_pixel(10'd1, 10'd0);
    send_pixel(10'd1023, 10'd1023);
    write_reg(REG_CELL, 10'd1023);
    send_pixel(10'd1022, 10'd1022);
    send_pixel(10'd1023, 10'd0);
    // A zero cell size behaves like a size of one.
    write_reg(REG_CELL, 10'd0);
    send_pixel(10'd6, 10'd3);
  endtask

  task automatic test_ring_widths();
    write_reg(REG_MODE, CFG_DATA_W'(MODE_RINGS));
    write_reg(REG_RING, 10'd1);
    send_pixel(10'd513, 10'd384);
    send_pixel(10'd0, 10'd0);
    write_reg(REG_RING, 10'd1023);
    send_pixel(10'd1023, 10'd1023);
    send_pixel(10'd0, 10'd767);
    // A zero ring width behaves like a width of one; rows below the frame still count.
    write_reg(REG_RING, 10'd0);
    send_pixel(10'd515, 10'd388);
    send_pixel(10'd1023, 10'd900);
  endtask

  task automatic test_random_traffic();
    int          burst;
    int          pick;
    logic [9:0]  x;
    logic [9:0]  y;
    logic [7:0]  junk;
    while (pixels_sent < 1270) begin
      gaps_on = ($urandom_range(0, 3) != 0);
      junk    = 8'($urandom_range(0, 255));
      pick    = $urandom_range(0, 9);
      write_reg(REG_MODE, {junk, (pick == 0) ? 2'd3 : (pick < 3) ? MODE_BLANK :
                                 (pick < 6) ? MODE_CHECKER : MODE_RINGS});
      junk = 8'($urandom_range(0, 255));
      write_reg(REG_BLANK, {junk[1:0], 8'($urandom_range(0, 255))});
      write_reg(REG_CELL, draw_size());
      write_reg(REG_RING, draw_size());
      burst = $urandom_range(20, 60);
      repeat (burst) begin
        pick = $urandom_range(0, 9);
        if (pick < 6) begin
          x = 10'($urandom_range(0, FRAME_WIDTH - 1));
          y = 10'($urandom_range(0, FRAME_HEIGHT - 1));
        end else if (pick < 8) begin
          // Close to the centre, where the root is small.
          x = 10'($urandom_range(CENTER_X - 40, CENTER_X + 40));
          y = 10'($urandom_range(CENTER_Y - 40, CENTER_Y + 40));
        end else begin
          x = 10'($urandom_range(0, 1023));
          y = 10'($urandom_range(FRAME_HEIGHT, 1023));
        end
        send_pixel(x, y);
      end
    end
  endtask

  initial begin
    rst_n       <= 1'b0;
    in_valid    <= 1'b0;
    in_pixel_x  <= '0;
    in_pixel_y  <= '0;
    cfg_valid   <= 1'b0;
    cfg_index   <= REG_MODE;
    cfg_data    <= '0;
    mode_q      = MODE_RESET;
    blank_q     = BLANK_RESET;
    cell_q      = CELL_RESET;
    ring_q      = RING_RESET;
    mismatches  = 0;
    pixels_sent = 0;
    gaps_on     = 1'b1;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_reset_defaults();
    test_blank_levels();
    test_checker_cells();
    test_ring_widths();
    test_random_traffic();

    in_valid <= 1'b0;
    while (expected_levels.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    if (expected_levels.size() != 0) begin
      mismatches++;
      $display("%0t: %0d words never arrived: expected %0d more, actual 0",
               $time, expected_levels.size(), expected_levels.size());
    end
    if (mismatches == 0)
      $display("[ OK ] regression clean");
    else
      $display("[FAIL] regression broken");
    $finish;
  end

endmodule
